// ===== rtl/kpt_pkg.sv =====
// ---------------------------------------------------------------------------
// kpt_pkg
// Shared types and constants of the keyword and punctuation tokenizer:
// token codes, keyword spellings and the token queue entry.
// ---------------------------------------------------------------------------
package kpt_pkg;

  // token codes
  localparam logic [4:0] KIND_PROGRAMME = 5'd0;
  localparam logic [4:0] KIND_IDENT     = 5'd6;
  localparam logic [4:0] KIND_STAR      = 5'd7;
  localparam logic [4:0] KIND_PLUS      = 5'd8;
  localparam logic [4:0] KIND_MINUS     = 5'd9;
  localparam logic [4:0] KIND_EQ        = 5'd10;
  localparam logic [4:0] KIND_ASSIGN    = 5'd11;
  localparam logic [4:0] KIND_LT        = 5'd12;
  localparam logic [4:0] KIND_GT        = 5'd13;
  localparam logic [4:0] KIND_COMMA     = 5'd14;
  localparam logic [4:0] KIND_COLON     = 5'd15;
  localparam logic [4:0] KIND_LPAREN    = 5'd16;
  localparam logic [4:0] KIND_RPAREN    = 5'd17;
  localparam logic [4:0] KIND_LBRACE    = 5'd18;
  localparam logic [4:0] KIND_RBRACE    = 5'd19;
  localparam logic [4:0] KIND_LBRACKET  = 5'd20;
  localparam logic [4:0] KIND_RBRACKET  = 5'd21;

  // keyword spellings, first character in the top byte, padded with spaces
  localparam int KW_COUNT = 6;
  localparam int KW_MAX   = 9;
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    "programme", "fonction ", "procedure", "variable ", "debut    ", "fin      "
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd9, 4'd8, 4'd9, 4'd8, 4'd5, 4'd3};

  // byte classes
  localparam logic [7:0] BYTE_UNDERSCORE = 8'd95;
  localparam logic [7:0] BYTE_LOWER_LO   = 8'd96;
  localparam logic [7:0] BYTE_LOWER_HI   = 8'd123;
  localparam logic [7:0] BYTE_MINUS      = 8'h2d;
  localparam logic [7:0] BYTE_LT         = 8'h3c;

  // token queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [4:0] kind;
    logic       last;
  } token_t;

  // up to two tokens from one input beat
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

// ===== rtl/keyword_punctuation_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// keyword_punctuation_tokenizer_top
// Keyword and punctuation tokenizer: one text byte per beat in, keyword,
// identifier and punctuation tokens out.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_stall in_text_byte          | input beat
//           | in_end_of_text                          |
//   out     | out_valid out_stall out_token_kind      | result beat
//           | out_last_of_run                         |
//
// one input beat a cycle while in_stall is low
// a beat giving two tokens sends them one after the other through the single
// output register draining the four-entry token queue
// in_stall rises when the queue has fewer than two free entries
// synchronous active-low reset clears the identifier, '<' and queue state
// ---------------------------------------------------------------------------
module keyword_punctuation_tokenizer_top #(
  parameter int KEYWORD_CHARS = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic       out_last_of_run
);

  logic            room;
  logic            accept;
  kpt_pkg::push_t  push;
  logic            pop_ready;
  logic            head_valid;
  kpt_pkg::token_t head;

  assign in_stall = !room;

  // classifier front end
  kpt_front #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .room           (room),
    .accept         (accept),
    .push           (push)
  );

  // token queue
  kpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .pop_ready  (pop_ready),
    .head_valid (head_valid),
    .head       (head)
  );

  // output stage
  kpt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop_ready       (pop_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_last_of_run (out_last_of_run)
  );

  // nothing is pushed without an accepted beat
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> push.count == 2'd0)
    else $error("token pushed without input beat");

endmodule

// ===== rtl/kpt_front.sv =====
// ---------------------------------------------------------------------------
// kpt_front
// Accepts text beats, tracks the open identifier and a waiting '<', and
// turns each beat into zero, one or two tokens pushed into the queue.
// ---------------------------------------------------------------------------
module kpt_front #(
  parameter int KEYWORD_CHARS = 9
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_text_byte,
  input  logic            in_end_of_text,
  input  logic            room,
  output logic            accept,
  output kpt_pkg::push_t  push
);

  localparam int LW = $clog2(KEYWORD_CHARS + 2);
  localparam int IW = $clog2(KEYWORD_CHARS);

  logic [7:0]    ident_chars_r [KEYWORD_CHARS];
  logic [LW-1:0] ident_length_r, ident_length_nxt;
  logic          in_identifier_r, in_identifier_nxt;
  logic          pending_lt_r, pending_lt_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          is_ident;
  logic          pre_v, post_v;
  logic [4:0]    pre_k, post_k, punct_k, kw_kind;
  logic          punct_v;
  logic          consumed;
  logic [LW-1:0] base_len;

  assign accept = in_valid && room;
  assign is_ident = (in_text_byte == kpt_pkg::BYTE_UNDERSCORE) ||
                    (in_text_byte > kpt_pkg::BYTE_LOWER_LO &&
                     in_text_byte < kpt_pkg::BYTE_LOWER_HI);

  // punctuation decode
  always_comb begin
    punct_v = 1'b1;
    unique case (in_text_byte)
      8'h2a:   punct_k = kpt_pkg::KIND_STAR;
      8'h2b:   punct_k = kpt_pkg::KIND_PLUS;
      8'h2d:   punct_k = kpt_pkg::KIND_MINUS;
      8'h3d:   punct_k = kpt_pkg::KIND_EQ;
      8'h3e:   punct_k = kpt_pkg::KIND_GT;
      8'h2c:   punct_k = kpt_pkg::KIND_COMMA;
      8'h3a:   punct_k = kpt_pkg::KIND_COLON;
      8'h28:   punct_k = kpt_pkg::KIND_LPAREN;
      8'h29:   punct_k = kpt_pkg::KIND_RPAREN;
      8'h7b:   punct_k = kpt_pkg::KIND_LBRACE;
      8'h7d:   punct_k = kpt_pkg::KIND_RBRACE;
      8'h5b:   punct_k = kpt_pkg::KIND_LBRACKET;
      8'h5d:   punct_k = kpt_pkg::KIND_RBRACKET;
      default: begin
        punct_v = 1'b0;
        punct_k = kpt_pkg::KIND_IDENT;
      end
    endcase
  end

  // keyword compare over the buffered bytes, lowest keyword wins
  always_comb begin
    logic hit;
    kw_kind = kpt_pkg::KIND_IDENT;
    for (int k = kpt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      hit = (ident_length_r == LW'(kpt_pkg::KW_LEN[k]));
      for (int j = 0; j < kpt_pkg::KW_MAX; j++) begin
        if (j < int'(kpt_pkg::KW_LEN[k]) &&
            ident_chars_r[j] != kpt_pkg::KW_TEXT[k][8*(kpt_pkg::KW_MAX-j)-1 -: 8])
          hit = 1'b0;
      end
      if (hit) kw_kind = 5'(k);
    end
  end

  // next state and token selection
  always_comb begin
    ident_length_nxt  = ident_length_r;
    in_identifier_nxt = in_identifier_r;
    pending_lt_nxt    = pending_lt_r;
    pre_v    = 1'b0;
    pre_k    = kpt_pkg::KIND_LT;
    post_v   = 1'b0;
    post_k   = punct_k;
    consumed = 1'b0;
    wr_en    = 1'b0;
    base_len = ident_length_r;
    if (in_end_of_text) begin
      pre_v             = pending_lt_r;
      ident_length_nxt  = '0;
      in_identifier_nxt = 1'b0;
      pending_lt_nxt    = 1'b0;
    end else begin
      if (in_identifier_r) begin
        if (is_ident) begin
          consumed = 1'b1;
          wr_en    = 1'b1;
        end else begin
          pre_v             = 1'b1;
          pre_k             = kw_kind;
          in_identifier_nxt = 1'b0;
          ident_length_nxt  = '0;
        end
      end else if (pending_lt_r) begin
        pending_lt_nxt = 1'b0;
        pre_v          = 1'b1;
        if (in_text_byte == kpt_pkg::BYTE_MINUS) begin
          pre_k    = kpt_pkg::KIND_ASSIGN;
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        if (is_ident) begin
          in_identifier_nxt = 1'b1;
          base_len          = '0;
          wr_en             = 1'b1;
        end else if (in_text_byte == kpt_pkg::BYTE_LT) begin
          pending_lt_nxt = 1'b1;
        end else begin
          post_v = punct_v;
        end
      end
      // append with saturating length
      if (wr_en) begin
        ident_length_nxt = (base_len <= LW'(KEYWORD_CHARS)) ? base_len + 1'b1 : base_len;
      end
    end
  end

  assign wr_idx = base_len[IW-1:0];

  // pack tokens into the queue push
  always_comb begin
    push = '0;
    if (pre_v) begin
      push.count     = post_v ? 2'd2 : 2'd1;
      push.tok0.kind = pre_k;
      push.tok0.last = !post_v;
      push.tok1.kind = post_k;
      push.tok1.last = 1'b1;
    end else if (post_v) begin
      push.count     = 2'd1;
      push.tok0.kind = post_k;
      push.tok0.last = 1'b1;
    end
    if (!accept) push.count = 2'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_length_r  <= '0;
      in_identifier_r <= 1'b0;
      pending_lt_r    <= 1'b0;
    end else if (accept) begin
      ident_length_r  <= ident_length_nxt;
      in_identifier_r <= in_identifier_nxt;
      pending_lt_r    <= pending_lt_nxt;
    end
  end

  // identifier byte buffer, no reset
  always_ff @(posedge clk) begin
    if (accept && wr_en && base_len < LW'(KEYWORD_CHARS)) begin
      ident_chars_r[wr_idx] <= in_text_byte;
    end
  end

  // an open identifier and a waiting '<' exclude each other
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_identifier_r && pending_lt_r))
    else $error("identifier and pending less-than both open");

  // an open identifier always holds at least one byte
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_identifier_r |-> ident_length_r != '0)
    else $error("open identifier with zero length");

endmodule

// ===== rtl/kpt_queue.sv =====
// ---------------------------------------------------------------------------
// kpt_queue
// Small token queue between front and back; takes up to two tokens a
// cycle and hands one a cycle to the back end while pop_ready is high.
// ---------------------------------------------------------------------------
module kpt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  kpt_pkg::push_t  push,
  output logic            room,
  input  logic            pop_ready,
  output logic            head_valid,
  output kpt_pkg::token_t head
);

  kpt_pkg::token_t mem_r [kpt_pkg::QUEUE_DEPTH];
  logic [kpt_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [kpt_pkg::QUEUE_CW-1:0] count_r, count_nxt;
  logic pop;

  assign room       = count_r <= kpt_pkg::QUEUE_CW'(kpt_pkg::QUEUE_DEPTH - 2);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid && pop_ready;
  assign wr_ptr1    = wr_ptr_r + 1'b1;
  assign count_nxt  = count_r + kpt_pkg::QUEUE_CW'(push.count)
                      - kpt_pkg::QUEUE_CW'(pop);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + kpt_pkg::QUEUE_AW'(push.count);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.tok0;
    if (push.count == 2'd2) mem_r[wr_ptr1]  <= push.tok1;
  end

  // fill count never passes the depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kpt_pkg::QUEUE_CW'(kpt_pkg::QUEUE_DEPTH))
    else $error("token queue overflow");

endmodule

// ===== rtl/kpt_back.sv =====
// ---------------------------------------------------------------------------
// kpt_back
// Output register of the result channel; pulls one token a cycle from the
// queue whenever the register is empty or being taken.
// ---------------------------------------------------------------------------
module kpt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  kpt_pkg::token_t head,
  output logic            pop_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      out_token_kind,
  output logic            out_last_of_run
);

  logic            out_valid_r;
  kpt_pkg::token_t out_tok_r;

  assign pop_ready       = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_tok_r.kind;
  assign out_last_of_run = out_tok_r.last;

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && head_valid) out_tok_r <= head;
  end

  // a waiting token fills an empty output register on the next edge
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !out_valid_r) |=> out_valid_r)
    else $error("queued token not moved to output");

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword and punctuation tokenizer. A short
// directed text hits most token codes, the '<' look-ahead and end of text.
// Random text built from keywords, near misses, names, punctuation and
// noise bytes follows. Both channels idle at random. A scoreboard predicts
// each token and checks it against the result beats in order.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_BEATS = 1950;
  localparam int IDLE_LIMIT = 5000;

  // token prediction and in-order checking
  class token_scoreboard;
    localparam int NAME_CHARS = kpt_pkg::KW_MAX;

    string             spellings[kpt_pkg::KW_COUNT];
    byte unsigned      name_buf[NAME_CHARS];
    int unsigned       name_len;
    bit                in_name;
    bit                lt_held;
    kpt_pkg::token_t   expected_q[$];
    int                errors;
    int                beats_seen;
    int                ends_seen;
    int                tokens_seen;
    int                keyword_hits;
    int                double_beats;

    function new();
      spellings = '{"programme", "fonction", "procedure", "variable", "debut", "fin"};
      name_len  = 0;
      in_name   = 1'b0;
      lt_held   = 1'b0;
    endfunction

    function bit is_name_byte(byte unsigned b);
      return b == kpt_pkg::BYTE_UNDERSCORE ||
             (b > kpt_pkg::BYTE_LOWER_LO && b < kpt_pkg::BYTE_LOWER_HI);
    endfunction

    // store while there is room, length saturates one past the buffer
    function void add_name_byte(byte unsigned b);
      if (name_len < NAME_CHARS) name_buf[name_len] = b;
      if (name_len <= NAME_CHARS) name_len++;
    endfunction

    function logic [4:0] keyword_or_name();
      bit same;
      for (int k = 0; k < kpt_pkg::KW_COUNT; k++) begin
        if (name_len == spellings[k].len()) begin
          same = 1'b1;
          for (int i = 0; i < name_len; i++)
            if (name_buf[i] != spellings[k][i]) same = 1'b0;
          if (same) return kpt_pkg::KIND_PROGRAMME + 5'(k);
        end
      end
      return kpt_pkg::KIND_IDENT;
    endfunction

    function bit punct_code(byte unsigned b, output logic [4:0] code);
      code = kpt_pkg::KIND_IDENT;
      case (b)
        "*": code = kpt_pkg::KIND_STAR;
        "+": code = kpt_pkg::KIND_PLUS;
        "-": code = kpt_pkg::KIND_MINUS;
        "=": code = kpt_pkg::KIND_EQ;
        ">": code = kpt_pkg::KIND_GT;
        ",": code = kpt_pkg::KIND_COMMA;
        ":": code = kpt_pkg::KIND_COLON;
        "(": code = kpt_pkg::KIND_LPAREN;
        ")": code = kpt_pkg::KIND_RPAREN;
        "{": code = kpt_pkg::KIND_LBRACE;
        "}": code = kpt_pkg::KIND_RBRACE;
        "[": code = kpt_pkg::KIND_LBRACKET;
        "]": code = kpt_pkg::KIND_RBRACKET;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // predict the tokens of one accepted input beat
    function void note_beat(byte unsigned b, bit eot);
      logic [4:0]      kinds[$];
      logic [4:0]      code;
      bit              taken;
      kpt_pkg::token_t t;
      beats_seen++;
      taken = 1'b0;
      if (eot) begin
        ends_seen++;
        if (lt_held) kinds.push_back(kpt_pkg::KIND_LT);
        name_len = 0;
        in_name  = 1'b0;
        lt_held  = 1'b0;
      end else begin
        // close an open name, or resolve a held '<'
        if (in_name) begin
          if (is_name_byte(b)) begin
            add_name_byte(b);
            taken = 1'b1;
          end else begin
            kinds.push_back(keyword_or_name());
            in_name  = 1'b0;
            name_len = 0;
          end
        end else if (lt_held) begin
          lt_held = 1'b0;
          if (b == kpt_pkg::BYTE_MINUS) begin
            kinds.push_back(kpt_pkg::KIND_ASSIGN);
            taken = 1'b1;
          end else begin
            kinds.push_back(kpt_pkg::KIND_LT);
          end
        end
        // the byte itself
        if (!taken) begin
          if (is_name_byte(b)) begin
            in_name  = 1'b1;
            name_len = 0;
            add_name_byte(b);
          end else if (b == kpt_pkg::BYTE_LT) begin
            lt_held = 1'b1;
          end else if (punct_code(b, code)) begin
            kinds.push_back(code);
          end
        end
      end
      if (kinds.size() > 1) double_beats++;
      foreach (kinds[i]) begin
        t.kind = kinds[i];
        t.last = (i == kinds.size() - 1);
        if (kinds[i] < kpt_pkg::KIND_IDENT) keyword_hits++;
        expected_q.push_back(t);
      end
    endfunction

    // compare one result beat with the oldest prediction
    function void check_token(logic [4:0] kind, logic last);
      kpt_pkg::token_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, got kind %0d last %0d",
                 $time, kind, last);
        return;
      end
      want = expected_q.pop_front();
      tokens_seen++;
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: token_kind mismatch: expected %0d, got %0d", $time, want.kind, kind);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %0d, got %0d", $time, want.last, last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [4:0] out_token_kind;
  logic       out_last_of_run;

  token_scoreboard sb = new();
  bit              tx_calm;
  int              blank_beats;
  int              idle_cycles;

  keyword_punctuation_tokenizer_top #(
    .KEYWORD_CHARS (kpt_pkg::KW_MAX)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_byte    (in_text_byte),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic byte unsigned random_name_byte();
    int r;
    r = $urandom_range(0, 26);
    return (r == 26) ? kpt_pkg::BYTE_UNDERSCORE : 8'("a" + r);
  endfunction

  // present one input beat and hold it until it is taken
  task automatic send_beat(byte unsigned b, bit eot);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b, eot);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // hold off the sender until every predicted token has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // one random word of text, glued to the next or followed by blanks
  task automatic send_word();
    int    r;
    int    k;
    int    n;
    int    pos;
    string w;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, kpt_pkg::KW_COUNT - 1);
    w = sb.spellings[k];
    if (r < 25) begin
      send_text(w);
    end else if (r < 37) begin
      // near miss of a keyword
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < w.len() - 1; i++) send_beat(w[i], 1'b0);
        1: begin
          send_text(w);
          send_beat(random_name_byte(), 1'b0);
        end
        default: begin
          pos = $urandom_range(0, w.len() - 1);
          for (int i = 0; i < w.len(); i++)
            send_beat((i == pos) ? random_name_byte() : w[i], 1'b0);
        end
      endcase
    end else if (r < 52) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
      repeat (n) send_beat(random_name_byte(), 1'b0);
    end else if (r < 67) begin
      w = "*+-=>,:(){}[]";
      send_beat(w[$urandom_range(0, w.len() - 1)], 1'b0);
    end else if (r < 74) begin
      send_beat(kpt_pkg::BYTE_LT, 1'b0);
      send_beat(kpt_pkg::BYTE_MINUS, 1'b0);
    end else if (r < 79) begin
      send_beat(kpt_pkg::BYTE_LT, 1'b0);
    end else if (r < 88) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 91) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 3) == 0) drain();
    end
    // separating blanks
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        send_beat(($urandom_range(0, 2) == 0) ? 8'h09 : 8'h20, 1'b0);
        blank_beats++;
      end
    end
  endtask

  // stimulus
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_text_byte   <= 8'h00;
    in_end_of_text <= 1'b0;
    tx_calm        = 1'b0;
    blank_beats    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: most token codes, '<' look-ahead, odd bytes, end of text
    send_text("fin(debut)<-a<b{}[]*+=>,:");
    send_beat(8'hff, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(kpt_pkg::BYTE_LT, 1'b0);
    send_beat(8'h7f, 1'b1);
    drain();

    // random text
    while (sb.beats_seen < TEXT_BEATS) begin
      if ($urandom_range(0, 60) == 0) tx_calm = !tx_calm;
      send_word();
    end
    send_beat(8'h00, 1'b1);
    drain();
    repeat (8) @(posedge clk);

    if (sb.expected_q.size() != 0)
      $display("%0t: %0d tokens never arrived", $time, sb.expected_q.size());
    $display("Covered %0d input beats (%0d blanks, %0d end marks), %0d tokens checked,",
             sb.beats_seen, blank_beats, sb.ends_seen, sb.tokens_seen);
    $display("  %0d of them keywords, %0d beats giving two tokens",
             sb.keyword_hits, sb.double_beats);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side back-pressure, with calm stretches
  initial begin
    int hold;
    int span;
    bit calm;
    out_stall <= 1'b0;
    hold = 0;
    span = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 300);
      end
      span--;
      if (hold == 0 && !calm) hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_token(out_token_kind, out_last_of_run);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule

// ===== files.f =====
rtl/kpt_pkg.sv
rtl/kpt_front.sv
rtl/kpt_queue.sv
rtl/kpt_back.sv
rtl/keyword_punctuation_tokenizer_top.sv
bench/tb_top.sv
